// ----- rtl/rcop_pkg.sv -----
// Package for the raised-cosine oscillation profile generator.
// Holds segment and register codes and the (1-cos)/2 weight function.
// No dependencies.
`timescale 1ns / 1ps

package rcop_pkg;

    // Segment of the run an item falls in
    typedef logic [1:0] seg_t;
    localparam seg_t SEG_RISE  = 2'd0;
    localparam seg_t SEG_SWING = 2'd1;
    localparam seg_t SEG_FALL  = 2'd2;

    // Where the segment base comes from for an item
    typedef logic [1:0] base_sel_t;
    localparam base_sel_t BASE_HOLD  = 2'd0;
    localparam base_sel_t BASE_START = 2'd1;
    localparam base_sel_t BASE_LAST  = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    localparam cfg_idx_t REG_AMPLITUDE    = 2'd0;
    localparam cfg_idx_t REG_PERIOD_TICKS = 2'd1;
    localparam cfg_idx_t REG_PERIOD_COUNT = 2'd2;
    localparam cfg_idx_t REG_PHASE_STEP   = 2'd3;

    // Field widths
    localparam int IO_POS_W  = 32;
    localparam int PERIOD_W  = 16;
    localparam int PHASE_W   = 24;
    localparam int STEP_W    = 25;
    localparam int WEIGHT_W  = 17;

    // Fixed-point constants, Q30
    localparam logic [63:0] PI_Q30  = 64'd3373259426;
    localparam logic [63:0] Q30_ONE = 64'd1073741824;

    // Weight (1-cos)/2 = sin^2 in Q16 for table index k of a 2^pb table.
    // Only evaluated at elaboration to fill the constant table.
    function automatic logic [WEIGHT_W-1:0] weight_q16(input int unsigned k_in,
                                                       input int unsigned pb);
        logic [63:0] m;
        logic [63:0] k;
        logic [63:0] x;
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] term;
        logic [63:0] s;
        logic [63:0] sq;
        longint      sum;
        m = 64'd1 << pb;
        k = 64'(k_in) & (m - 64'd1);
        if (k > (m >> 1))
        begin
            k = m - k;
        end
        x = k << (30 - pb);
        a = (x * PI_Q30) >> 30;
        a2 = (a * a) >> 30;
        term = a;
        sum = longint'(a);
        // Odd Taylor terms up to the ninth power
        term = ((term * a2) >> 30) / 64'd6;
        sum = sum - longint'(term);
        term = ((term * a2) >> 30) / 64'd20;
        sum = sum + longint'(term);
        term = ((term * a2) >> 30) / 64'd42;
        sum = sum - longint'(term);
        term = ((term * a2) >> 30) / 64'd72;
        sum = sum + longint'(term);
        if (sum < 0)
        begin
            sum = 0;
        end
        s = 64'(sum);
        if (s > Q30_ONE)
        begin
            s = Q30_ONE;
        end
        sq = (s * s) >> 30;
        sq = (sq + 64'd8192) >> 14;
        if (sq > 64'd65536)
        begin
            sq = 64'd65536;
        end
        return sq[WEIGHT_W-1:0];
    endfunction

endpackage

// ----- rtl/raised_cosine_oscillation_profile_top.sv -----
// Raised-cosine oscillation profile generator, top level. Depends on rcop_pkg.
// Pipeline: an accepted input passes the input stage register and the output
// register before its result is valid (input stage, compute stage). Throughput:
// one item per cycle while out_stall is low; the input stage reads the weight
// table, the compute stage closes the position loop (33x17 multiply, add, saturate).
// Reset: async active low; run state, positions and phase zero, registers to defaults.
`timescale 1ns / 1ps

module raised_cosine_oscillation_profile_top #(
    parameter int PHASE_BITS = 10,
    parameter int POS_WIDTH  = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // Configuration write port
    input  logic                        cfg_write_en,
    input  rcop_pkg::cfg_idx_t          cfg_index,
    input  logic [rcop_pkg::CFG_DATA_W-1:0] cfg_data,
    // Input channel
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [rcop_pkg::IO_POS_W-1:0] start_position,
    // Output channel
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [rcop_pkg::IO_POS_W-1:0] target_position,
    output logic                        run_done
);
    import rcop_pkg::*;

    localparam int HALF   = 2 ** (PHASE_BITS - 1);
    localparam int BASE_W = (POS_WIDTH > IO_POS_W) ? POS_WIDTH : IO_POS_W;
    localparam int SUM_W  = ((BASE_W > 34) ? BASE_W : 34) + 1;
    localparam int CNT_W  = 2 * PERIOD_W;
    localparam int CMP_W  = CNT_W + 2;

    localparam logic signed [SUM_W-1:0] POS_MAX =
        {{(SUM_W - POS_WIDTH + 1){1'b0}}, {(POS_WIDTH - 1){1'b1}}};
    localparam logic signed [SUM_W-1:0] POS_MIN = ~POS_MAX;

    // Configuration registers
    logic signed [IO_POS_W-1:0] amplitude_reg;
    logic [PERIOD_W-1:0]        period_ticks_reg;
    logic [PERIOD_W-1:0]        period_count_reg;
    logic [STEP_W-1:0]          phase_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amplitude_reg    <= '0;
            period_ticks_reg <= PERIOD_W'(1000);
            period_count_reg <= PERIOD_W'(2);
            phase_step_reg   <= STEP_W'(16777);
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                REG_AMPLITUDE:    amplitude_reg    <= cfg_data[IO_POS_W-1:0];
                REG_PERIOD_TICKS: period_ticks_reg <= cfg_data[PERIOD_W-1:0];
                REG_PERIOD_COUNT: period_count_reg <= cfg_data[PERIOD_W-1:0];
                REG_PHASE_STEP:   phase_step_reg   <= cfg_data[STEP_W-1:0];
                default:          ;
            endcase
        end
    end

    // Weight table, folded on the half-period symmetry
    logic [WEIGHT_W-1:0] weight_tab [HALF+1];
    for (genvar g = 0; g <= HALF; g++)
    begin : g_weight_tab
        assign weight_tab[g] = weight_q16(g, PHASE_BITS);
    end

    // Handshake and pipeline control
    logic s1_valid_reg;
    logic s1_advance;
    logic in_accept;

    assign s1_advance = s1_valid_reg && !(out_valid && out_stall);
    assign in_stall   = s1_valid_reg && !s1_advance;
    assign in_accept  = in_valid && !in_stall;

    // Input stage: tick counting, segment decision, phase and weight lookup
    logic [CNT_W-1:0]   tick_count_reg;
    logic [CNT_W-1:0]   tick_count_next;
    logic [PHASE_W-1:0] phase_accum_reg;
    logic [PHASE_W-1:0] phase_accum_next;
    logic [CNT_W-1:0]   run_len;
    logic [CMP_W-1:0]   half_len;
    logic [CMP_W-1:0]   tick_num;
    logic [CMP_W-1:0]   swing_end;
    logic               past_end;
    logic               at_end;
    logic               restart;
    seg_t               seg_next;
    base_sel_t          base_sel_next;
    logic [PHASE_BITS-1:0] tab_raw;
    logic [PHASE_BITS-1:0] tab_idx;

    always_comb
    begin
        run_len   = CNT_W'(period_count_reg) * CNT_W'(period_ticks_reg);
        half_len  = CMP_W'(period_ticks_reg >> 1);
        tick_num  = CMP_W'(tick_count_reg) + CMP_W'(1);
        swing_end = CMP_W'(run_len) - half_len;
        past_end  = tick_num > CMP_W'(run_len);
        at_end    = past_end || (tick_num >= CMP_W'(run_len));

        // Segment base and phase restart
        base_sel_next = BASE_HOLD;
        restart       = 1'b0;
        if (tick_num == CMP_W'(1))
        begin
            base_sel_next = BASE_START;
            restart       = 1'b1;
        end
        else if ((tick_num == half_len + CMP_W'(1)) ||
                 (tick_num == swing_end + CMP_W'(1)))
        begin
            base_sel_next = BASE_LAST;
            restart       = 1'b1;
        end

        if (tick_num <= half_len)
        begin
            seg_next = SEG_RISE;
        end
        else if (tick_num <= swing_end)
        begin
            seg_next = SEG_SWING;
        end
        else
        begin
            seg_next = SEG_FALL;
        end

        // Phase accumulator holds still on ticks past the end
        if (past_end)
        begin
            phase_accum_next = phase_accum_reg;
        end
        else if (restart)
        begin
            phase_accum_next = phase_step_reg[PHASE_W-1:0];
        end
        else
        begin
            phase_accum_next = phase_accum_reg + phase_step_reg[PHASE_W-1:0];
        end

        tick_count_next = at_end ? '0 : tick_num[CNT_W-1:0];

        tab_raw = phase_accum_next[PHASE_W-1 -: PHASE_BITS];
        if (tab_raw > PHASE_BITS'(HALF))
        begin
            tab_idx = PHASE_BITS'((PHASE_BITS + 1)'(2 * HALF) - (PHASE_BITS + 1)'(tab_raw));
        end
        else
        begin
            tab_idx = tab_raw;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg  <= '0;
            phase_accum_reg <= '0;
        end
        else if (in_accept)
        begin
            tick_count_reg  <= tick_count_next;
            phase_accum_reg <= phase_accum_next;
        end
    end

    // Stage-1 registers
    logic                       s1_past_reg;
    logic                       s1_done_reg;
    seg_t                       s1_seg_reg;
    base_sel_t                  s1_base_sel_reg;
    logic signed [IO_POS_W-1:0] s1_start_reg;
    logic [WEIGHT_W-1:0]        s1_weight_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_past_reg     <= past_end;
            s1_done_reg     <= at_end;
            s1_seg_reg      <= seg_next;
            s1_base_sel_reg <= base_sel_next;
            s1_start_reg    <= start_position;
            s1_weight_reg   <= weight_tab[tab_idx];
        end
    end

    // Compute stage: base select, scaled delta, add and saturate
    logic signed [BASE_W-1:0]    segment_base_reg;
    logic signed [POS_WIDTH-1:0] last_output_reg;
    logic signed [BASE_W-1:0]    base_eff;
    logic [IO_POS_W-1:0]         amp_mag;
    logic [IO_POS_W:0]           amp_scaled;
    logic [49:0]                 prod;
    logic [49:0]                 prod_rnd;
    logic [33:0]                 delta_mag;
    logic                        delta_neg;
    logic signed [SUM_W-1:0]     delta;
    logic signed [SUM_W-1:0]     pos_sum;
    logic signed [POS_WIDTH-1:0] pos_sat;
    logic signed [POS_WIDTH-1:0] pos_final;
    logic signed [BASE_W-1:0]    pos_wide;

    always_comb
    begin
        case (s1_base_sel_reg)
            BASE_START: base_eff = BASE_W'(s1_start_reg);
            BASE_LAST:  base_eff = BASE_W'(last_output_reg);
            default:    base_eff = segment_base_reg;
        endcase

        amp_mag    = amplitude_reg[IO_POS_W-1] ? IO_POS_W'(-amplitude_reg)
                                               : IO_POS_W'(amplitude_reg);
        amp_scaled = (s1_seg_reg == SEG_SWING) ? {amp_mag, 1'b0} : {1'b0, amp_mag};
        prod       = 50'(amp_scaled) * 50'(s1_weight_reg);
        prod_rnd   = prod + 50'd32768;
        delta_mag  = prod_rnd[49:16];
        delta_neg  = amplitude_reg[IO_POS_W-1] ^ (s1_seg_reg != SEG_RISE);
        delta      = delta_neg ? -SUM_W'(delta_mag) : SUM_W'(delta_mag);

        pos_sum = SUM_W'(base_eff) + delta;
        if (pos_sum > POS_MAX)
        begin
            pos_sat = POS_MAX[POS_WIDTH-1:0];
        end
        else if (pos_sum < POS_MIN)
        begin
            pos_sat = POS_MIN[POS_WIDTH-1:0];
        end
        else
        begin
            pos_sat = pos_sum[POS_WIDTH-1:0];
        end

        // Ticks past the end hold the last output
        pos_final = s1_past_reg ? last_output_reg : pos_sat;
        pos_wide  = BASE_W'(pos_final);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segment_base_reg <= '0;
            last_output_reg  <= '0;
        end
        else if (s1_advance && !s1_past_reg)
        begin
            segment_base_reg <= base_eff;
            last_output_reg  <= pos_sat;
        end
    end

    // Output register
    logic                       out_valid_reg;
    logic signed [IO_POS_W-1:0] target_position_reg;
    logic                       run_done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            target_position_reg <= pos_wide[IO_POS_W-1:0];
            run_done_reg        <= s1_done_reg;
        end
    end

    assign out_valid       = out_valid_reg;
    assign target_position = target_position_reg;
    assign run_done        = run_done_reg;

endmodule

// ----- bench/tb_raised_cosine_oscillation_profile_top.sv -----
// Self-checking bench for the raised-cosine oscillation profile generator.
// A directed table, then random register settings and ticks, checked against
// a bit-exact predictor with random idling on both channels. Uses rcop_pkg.
`timescale 1ns / 1ps

module tb_raised_cosine_oscillation_profile_top;

    import rcop_pkg::*;

    localparam int PB            = 10;
    localparam int POS_W         = 32;
    localparam int RANDOM_TICKS  = 700;
    localparam int QUIET_AFTER   = 600;
    localparam int LONG_HOLD     = 200;
    localparam int MAX_REPORTS   = 40;
    localparam int DIRECTED_ROWS = 42;

    // One expected result
    typedef struct packed {
        logic [31:0] pos;
        logic        done;
    } target_t;

    // Directed table row: a register write or a tick
    typedef enum logic {ROW_TICK, ROW_REG} row_kind_e;
    typedef struct packed {
        row_kind_e   kind;
        cfg_idx_t    idx;
        logic [31:0] value;
        logic        typed;
        logic [31:0] exp_pos;
        logic        exp_done;
    } stim_row_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write_en;
    cfg_idx_t              cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic signed [31:0]    start_position;
    logic                  out_valid;
    logic                  out_stall;
    logic signed [31:0]    target_position;
    logic                  run_done;

    // Predictor copy of the registers and the run state
    longint          amp_reg;
    longint          period_reg;
    longint          count_reg;
    logic [24:0]     step_reg;
    longint          tick_cnt;
    longint          seg_base;
    longint          last_pos;
    logic [23:0]     phase_acc;

    target_t target_q [$];
    int      err_cnt;
    int      ticks_sent;
    int      tx_idle_pct;
    int      rx_idle_pct;
    int      hold_req;

    raised_cosine_oscillation_profile_top #(
        .PHASE_BITS (PB),
        .POS_WIDTH  (POS_W)
    ) u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .start_position  (start_position),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .target_position (target_position),
        .run_done        (run_done)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // (1-cos)/2 as sin^2 in Q16 from a truncated Taylor series in Q30
    function automatic logic [16:0] half_cos_weight(input int unsigned idx);
        longint unsigned span;
        longint unsigned k;
        longint unsigned ang;
        longint unsigned ang_sq;
        longint unsigned term;
        longint unsigned sine;
        longint unsigned sq;
        longint          acc;
        span = 64'd1 << PB;
        k = 64'(idx) & (span - 64'd1);
        if (k > span / 2)
        begin
            k = span - k;
        end
        ang = ((k << (30 - PB)) * PI_Q30) >> 30;
        ang_sq = (ang * ang) >> 30;
        term = ang;
        acc = longint'(ang);
        for (int i = 1; i <= 4; i++)
        begin
            term = ((term * ang_sq) >> 30) / 64'((2 * i) * (2 * i + 1));
            if (i % 2 == 1)
            begin
                acc = acc - longint'(term);
            end
            else
            begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0)
        begin
            acc = 0;
        end
        sine = 64'(acc);
        if (sine > Q30_ONE)
        begin
            sine = Q30_ONE;
        end
        sq = (((sine * sine) >> 30) + 64'd8192) >> 14;
        if (sq > 64'd65536)
        begin
            sq = 64'd65536;
        end
        return sq[16:0];
    endfunction

    // One servo tick of the profile: updates the run state, returns the result
    task automatic advance_profile(input logic [31:0] sp, output target_t res);
        longint          half;
        longint          total;
        longint          c;
        longint          pos;
        longint          prod;
        longint          delta;
        longint          hi;
        longint          lo;
        longint unsigned mag;
        logic [16:0]     w;
        logic            restart;
        logic            done;
        seg_t            seg;
        half = period_reg / 2;
        total = count_reg * period_reg;
        c = tick_cnt + 1;
        hi = (longint'(1) << (POS_W - 1)) - 1;
        lo = -hi - 1;
        if (c > total)
        begin
            // past the end of the run: hold the last output
            pos = last_pos;
            done = 1'b1;
        end
        else
        begin
            restart = 1'b0;
            if (c == 1)
            begin
                seg_base = longint'(signed'(sp));
                restart = 1'b1;
            end
            else if (c == half + 1 || c == total - half + 1)
            begin
                seg_base = last_pos;
                restart = 1'b1;
            end
            if (restart)
            begin
                phase_acc = step_reg[23:0];
            end
            else
            begin
                phase_acc = phase_acc + step_reg[23:0];
            end
            if (c <= half)
            begin
                seg = SEG_RISE;
            end
            else if (c <= total - half)
            begin
                seg = SEG_SWING;
            end
            else
            begin
                seg = SEG_FALL;
            end
            case (seg)
                SEG_RISE:  prod = amp_reg;
                SEG_SWING: prod = -2 * amp_reg;
                default:   prod = -amp_reg;
            endcase
            w = half_cos_weight(int'(phase_acc[23 -: PB]));
            // round to nearest, ties away from zero
            mag = (prod < 0) ? 64'(-prod) : 64'(prod);
            mag = (mag * 64'(w) + 64'd32768) >> 16;
            delta = (prod < 0) ? -longint'(mag) : longint'(mag);
            pos = seg_base + delta;
            if (pos > hi)
            begin
                pos = hi;
            end
            else if (pos < lo)
            begin
                pos = lo;
            end
            last_pos = pos;
            done = (c >= total);
        end
        tick_cnt = done ? 0 : c;
        res.pos = pos[31:0];
        res.done = done;
    endtask

    // Register write, mirrored into the predictor
    task automatic program_reg(input cfg_idx_t idx, input logic [31:0] val);
        cfg_write_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_write_en <= 1'b0;
        case (idx)
            REG_AMPLITUDE:    amp_reg = longint'(signed'(val));
            REG_PERIOD_TICKS: period_reg = longint'(val[15:0]);
            REG_PERIOD_COUNT: count_reg = longint'(val[15:0]);
            default:          step_reg = val[24:0];
        endcase
        @(posedge clk);
    endtask

    // Stop offering ticks until every result is back and the pipe is empty
    task automatic drain_targets();
        in_valid <= 1'b0;
        while (target_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (3) @(posedge clk);
    endtask

    // Offer one tick; on accept push the typed or the predicted result
    task automatic offer_tick(input logic [31:0] sp, input logic typed,
                              input logic [31:0] tpos, input logic tdone);
        target_t res;
        if (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        start_position <= sp;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        advance_profile(sp, res);
        if (typed)
        begin
            res.pos = tpos;
            res.done = tdone;
        end
        target_q.push_back(res);
        ticks_sent++;
    endtask

    // Result side: checks accepted results and drives stall
    initial
    begin
        int      stall_left;
        int      hold_left;
        target_t want;
        stall_left = 0;
        hold_left = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (target_q.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= MAX_REPORTS)
                    begin
                        $display("%0t: unexpected result pos=%0d done=%0b", $realtime,
                                 target_position, run_done);
                    end
                end
                else
                begin
                    want = target_q.pop_front();
                    if (want.pos !== target_position)
                    begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS)
                        begin
                            $display("%0t: target_position expected %0d actual %0d",
                                     $realtime, signed'(want.pos), target_position);
                        end
                    end
                    if (want.done !== run_done)
                    begin
                        err_cnt++;
                        if (err_cnt <= MAX_REPORTS)
                        begin
                            $display("%0t: run_done expected %0b actual %0b",
                                     $realtime, want.done, run_done);
                        end
                    end
                end
            end
            // long hold-off on request, else short random bursts
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (rx_idle_pct > 0 && $urandom_range(0, 99) < rx_idle_pct)
            begin
                stall_left = $urandom_range(0, 6);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Timeout
    initial
    begin
        #3_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Stimulus
    initial
    begin
        stim_row_t   rows [DIRECTED_ROWS];
        int          phase;
        int          len;
        int          pick;
        longint      total;
        logic [31:0] val;
        logic [31:0] sp;

        rst_n = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = REG_AMPLITUDE;
        cfg_data = '0;
        in_valid = 1'b0;
        start_position = '0;
        err_cnt = 0;
        ticks_sent = 0;
        hold_req = 0;
        tx_idle_pct = 20;
        rx_idle_pct = 20;
        amp_reg = 0;
        period_reg = 1000;
        count_reg = 2;
        step_reg = 25'd16777;
        tick_cnt = 0;
        seg_base = 0;
        last_pos = 0;
        phase_acc = '0;

        rows = '{
            // after reset, zero amplitude: output is the latched start
            '{ROW_TICK, REG_AMPLITUDE, 32'h7FFFFFFF, 1'b1, 32'h7FFFFFFF, 1'b0},
            '{ROW_TICK, REG_AMPLITUDE, 32'h80000000, 1'b1, 32'h7FFFFFFF, 1'b0},
            // run length cut to zero mid run: ticks past the end hold
            '{ROW_REG,  REG_PERIOD_COUNT, 32'd0, 1'b0, 32'h0, 1'b0},
            '{ROW_TICK, REG_AMPLITUDE, 32'h00000000, 1'b1, 32'h7FFFFFFF, 1'b1},
            '{ROW_TICK, REG_AMPLITUDE, 32'h12345678, 1'b1, 32'h7FFFFFFF, 1'b1},
            // period of one: no rising segment, start still latched
            '{ROW_REG,  REG_PERIOD_TICKS, 32'd1, 1'b0, 32'h0, 1'b0},
            '{ROW_REG,  REG_PERIOD_COUNT, 32'd1, 1'b0, 32'h0, 1'b0},
            '{ROW_TICK, REG_AMPLITUDE, 32'h80000000, 1'b1, 32'h80000000, 1'b1},
            // period of zero: every tick is past the end
            '{ROW_REG,  REG_PERIOD_TICKS, 32'd0, 1'b0, 32'h0, 1'b0},
            '{ROW_TICK, REG_AMPLITUDE, 32'h00000005, 1'b1, 32'h80000000, 1'b1},
            // full amplitude, half-turn phase: weight is exactly one
            '{ROW_REG,  REG_AMPLITUDE, 32'h7FFFFFFF, 1'b0, 32'h0, 1'b0},
            '{ROW_REG,  REG_PERIOD_TICKS, 32'd2, 1'b0, 32'h0, 1'b0},
            '{ROW_REG,  REG_PERIOD_COUNT, 32'd1, 1'b0, 32'h0, 1'b0},
            '{ROW_REG,  REG_PHASE_STEP, 32'h00800000, 1'b0, 32'h0, 1'b0},
            '{ROW_TICK, REG_AMPLITUDE, 32'h00000000, 1'b1, 32'h7FFFFFFF, 1'b0},
            '{ROW_TICK, REG_AMPLITUDE, 32'h55555555, 1'b1, 32'h00000000, 1'b1},
            // positive and negative saturation
            '{ROW_TICK, REG_AMPLITUDE, 32'h00000005, 1'b1, 32'h7FFFFFFF, 1'b0},
            '{ROW_TICK, REG_AMPLITUDE, 32'h00000000, 1'b1, 32'h00000000, 1'b1},
            '{ROW_REG,  REG_AMPLITUDE, 32'h80000000, 1'b0, 32'h0, 1'b0},
            '{ROW_TICK, REG_AMPLITUDE, 32'hFFFFFFFF, 1'b1, 32'h80000000, 1'b0},
            '{ROW_TICK, REG_AMPLITUDE, 32'hAAAAAAAA, 1'b1, 32'h00000000, 1'b1},
            // full-turn step wraps to zero phase: no movement
            '{ROW_REG,  REG_PHASE_STEP, 32'h01000000, 1'b0, 32'h0, 1'b0},
            '{ROW_TICK, REG_AMPLITUDE, 32'h0F0F0F0F, 1'b1, 32'h0F0F0F0F, 1'b0},
            '{ROW_TICK, REG_AMPLITUDE, 32'hF0F0F0F0, 1'b1, 32'h0F0F0F0F, 1'b1},
            // a full two-period run through all three segments
            '{ROW_REG,  REG_AMPLITUDE, 32'd1000000, 1'b0, 32'h0, 1'b0},
            '{ROW_REG,  REG_PERIOD_TICKS, 32'd4, 1'b0, 32'h0, 1'b0},
            '{ROW_REG,  REG_PERIOD_COUNT, 32'd2, 1'b0, 32'h0, 1'b0},
            '{ROW_REG,  REG_PHASE_STEP, 32'h00400000, 1'b0, 32'h0, 1'b0},
            '{ROW_TICK, REG_AMPLITUDE, 32'hFFF00000, 1'b0, 32'h0, 1'b0},
            '{ROW_TICK, REG_AMPLITUDE, 32'h00000001, 1'b0, 32'h0, 1'b0},
            '{ROW_TICK, REG_AMPLITUDE, 32'h00000002, 1'b0, 32'h0, 1'b0},
            '{ROW_TICK, REG_AMPLITUDE, 32'h00000003, 1'b0, 32'h0, 1'b0},
            '{ROW_TICK, REG_AMPLITUDE, 32'h00000004, 1'b0, 32'h0, 1'b0},
            '{ROW_TICK, REG_AMPLITUDE, 32'h00000005, 1'b0, 32'h0, 1'b0},
            '{ROW_TICK, REG_AMPLITUDE, 32'h00000006, 1'b0, 32'h0, 1'b0},
            '{ROW_TICK, REG_AMPLITUDE, 32'h00000007, 1'b0, 32'h0, 1'b0},
            // odd period
            '{ROW_REG,  REG_PERIOD_TICKS, 32'd3, 1'b0, 32'h0, 1'b0},
            '{ROW_REG,  REG_PERIOD_COUNT, 32'd1, 1'b0, 32'h0, 1'b0},
            '{ROW_REG,  REG_PHASE_STEP, 32'h00555555, 1'b0, 32'h0, 1'b0},
            '{ROW_TICK, REG_AMPLITUDE, 32'h7FFF0000, 1'b0, 32'h0, 1'b0},
            '{ROW_TICK, REG_AMPLITUDE, 32'h00000000, 1'b0, 32'h0, 1'b0},
            '{ROW_TICK, REG_AMPLITUDE, 32'h00000000, 1'b0, 32'h0, 1'b0}
        };

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table
        foreach (rows[i])
        begin
            if (rows[i].kind == ROW_REG)
            begin
                drain_targets();
                program_reg(rows[i].idx, rows[i].value);
            end
            else
            begin
                offer_tick(rows[i].value, rows[i].typed, rows[i].exp_pos,
                           rows[i].exp_done);
            end
        end

        // Random phases: new register settings, then a stretch of ticks
        phase = 0;
        ticks_sent = 0;
        while (ticks_sent < RANDOM_TICKS)
        begin
            drain_targets();
            if (ticks_sent >= QUIET_AFTER)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            else
            begin
                pick = $urandom_range(0, 2);
                tx_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
                pick = $urandom_range(0, 2);
                rx_idle_pct = (pick == 0) ? 0 : (pick == 1) ? 15 : 40;
            end

            if (phase == 0 || $urandom_range(0, 3) != 0)
            begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                begin
                    val = 32'h7FFFFFFF;
                end
                else if (pick == 1)
                begin
                    val = 32'h80000000;
                end
                else if (pick < 4)
                begin
                    val = $urandom;
                end
                else
                begin
                    val = 32'($urandom_range(0, 2097152)) - 32'd1048576;
                end
                program_reg(REG_AMPLITUDE, val);
            end
            if (phase == 0 || $urandom_range(0, 3) != 0)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                begin
                    val = $urandom_range(2, 12);
                end
                else if (pick == 7)
                begin
                    val = $urandom_range(13, 64);
                end
                else if (pick == 8)
                begin
                    case ($urandom_range(0, 2))
                        0:       val = 32'd0;
                        1:       val = 32'd1;
                        default: val = 32'd65535;
                    endcase
                end
                else
                begin
                    val = $urandom_range(0, 65535);
                end
                program_reg(REG_PERIOD_TICKS, val);
            end
            if (phase == 0 || $urandom_range(0, 3) != 0)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 7)
                begin
                    val = $urandom_range(1, 3);
                end
                else if (pick == 7)
                begin
                    val = $urandom_range(4, 10);
                end
                else if (pick == 8)
                begin
                    val = ($urandom_range(0, 1) == 0) ? 32'd0 : 32'd65535;
                end
                else
                begin
                    val = $urandom_range(0, 65535);
                end
                program_reg(REG_PERIOD_COUNT, val);
            end
            if (phase == 0 || $urandom_range(0, 3) != 0)
            begin
                // mostly one turn per period, as software would set it
                val = (period_reg > 0) ? 32'(longint'(1 << 24) / period_reg) : 32'd0;
                pick = $urandom_range(0, 9);
                if (pick == 6)
                begin
                    val = val + $urandom_range(0, 4095);
                end
                else if (pick == 7)
                begin
                    val = $urandom & 32'h01FFFFFF;
                end
                else if (pick == 8)
                begin
                    val = 32'd0;
                end
                else if (pick == 9)
                begin
                    val = 32'h01000000;
                end
                program_reg(REG_PHASE_STEP, val);
            end

            // once, hold off the result side long enough to back up the input
            if (phase == 2)
            begin
                tx_idle_pct = 0;
                hold_req = LONG_HOLD;
            end

            total = count_reg * period_reg;
            if (total >= 1 && total <= 40)
            begin
                len = int'(total) * $urandom_range(1, 2) + $urandom_range(0, 3);
            end
            else
            begin
                len = $urandom_range(8, 40);
            end
            for (int i = 0; i < len; i++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                begin
                    sp = $urandom;
                end
                else if (pick < 8)
                begin
                    sp = 32'($urandom_range(0, 131072)) - 32'd65536;
                end
                else
                begin
                    sp = ($urandom_range(0, 1) == 0) ? 32'h7FFFFFFF : 32'h80000000;
                end
                offer_tick(sp, 1'b0, 32'h0, 1'b0);
            end
            phase++;
        end

        // Wind down and report
        drain_targets();
        repeat (8) @(posedge clk);
        if (err_cnt == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/rcop_pkg.sv
rtl/raised_cosine_oscillation_profile_top.sv
bench/tb_raised_cosine_oscillation_profile_top.sv
